// ===== design/wis_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the weighted index sampler.
`default_nettype none

package wis_pkg;

  localparam int INDEX_W     = 10;
  localparam int TABLE_DEPTH = 1 << INDEX_W;
  localparam int FRAC_W      = 24;
  localparam int WEIGHT_W    = FRAC_W + 1;
  localparam int COUNT_W     = 11;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int KIND_W      = 2;
  // running skipped mass: signed sum of up to TABLE_DEPTH entry masses
  localparam int SKIP_W      = WEIGHT_W + INDEX_W + 2;
  localparam int DIFF_W      = SKIP_W + 1;
  localparam int RHS_W       = FRAC_W + WEIGHT_W;

  localparam logic [WEIGHT_W-1:0] ONE_FX    = WEIGHT_W'(1) << FRAC_W;
  localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_VETO  = 2'd1,
    KIND_DRAW  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WITH_REPL   = 2'd0,
    CFG_ENTRY_COUNT = 2'd1,
    CFG_SAMPLE_TGT  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic load_wr;
    logic capture;
    logic clear_batch;
    logic sweep;
    logic setup;
    logic walk;
    logic veto_prev;
    logic veto_cur;
    logic veto_apply;
    logic decide;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic walk_end;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/wis_ctrl.sv =====
// Sequencing state machine of the weighted index sampler.
`default_nettype none

module wis_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [wis_pkg::KIND_W-1:0]     kind,
  output logic                                in_ready,
  output wis_pkg::dp_cmd_t                    cmd,
  input  wire wis_pkg::dp_stat_t              stat
);
  import wis_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE       = 9'b000000001,
    ST_SWEEP      = 9'b000000010,
    ST_SETUP      = 9'b000000100,
    ST_WALK       = 9'b000001000,
    ST_DECIDE     = 9'b000010000,
    ST_VETO_PREV  = 9'b000100000,
    ST_VETO_CUR   = 9'b001000000,
    ST_VETO_APPLY = 9'b010000000,
    ST_SPARE      = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          unique case (kind_t'(kind))
            KIND_LOAD:  cmd.load_wr = 1'b1;
            KIND_VETO:  state_next = ST_VETO_PREV;
            KIND_DRAW:  state_next = ST_SETUP;
            KIND_CLEAR: begin
              cmd.clear_batch = 1'b1;
              state_next      = ST_SWEEP;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_end) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat.out_free) begin
          cmd.decide = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_VETO_PREV: begin
        cmd.veto_prev = 1'b1;
        state_next    = ST_VETO_CUR;
      end
      ST_VETO_CUR: begin
        cmd.veto_cur = 1'b1;
        state_next   = ST_VETO_APPLY;
      end
      ST_VETO_APPLY: begin
        cmd.veto_apply = 1'b1;
        state_next     = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  a_walk_to_decide: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && stat.walk_end) |=> (state == ST_DECIDE))
    else $error("walk end did not reach decide");

  a_decide_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> stat.out_free)
    else $error("result written over a pending result");

endmodule

`default_nettype wire

// ===== design/wis_dp.sv =====
// Datapath: weight table, mark memory, search walk, batch state and result register.
`default_nettype none

module wis_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [wis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wis_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic [wis_pkg::INDEX_W-1:0]       entry_index,
  input  wire logic [wis_pkg::WEIGHT_W-1:0]      cumulative_weight,
  input  wire logic [wis_pkg::FRAC_W-1:0]        random_fraction,
  input  wire wis_pkg::dp_cmd_t                  cmd,
  output wis_pkg::dp_stat_t                      stat,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [wis_pkg::INDEX_W-1:0]            drawn_index,
  output logic                                   accepted,
  output logic                                   batch_done
);
  import wis_pkg::*;

  localparam int VETO_BIT = 1;
  localparam int SAMP_BIT = 0;

  // saturating update of removed mass by one entry's weight
  function automatic logic [WEIGHT_W-1:0] add_mass(input logic [WEIGHT_W-1:0] base,
                                                   input logic [WEIGHT_W-1:0] w,
                                                   input logic [WEIGHT_W-1:0] p);
    logic signed [WEIGHT_W+1:0] s;
    s = $signed({2'b00, base}) + $signed({2'b00, w}) - $signed({2'b00, p});
    if (s < 0) begin
      add_mass = '0;
    end else if (s > $signed({2'b00, ONE_FX})) begin
      add_mass = ONE_FX;
    end else begin
      add_mass = s[WEIGHT_W-1:0];
    end
  endfunction

  // config registers
  logic                with_replacement;
  logic [COUNT_W-1:0]  entry_count;
  logic [COUNT_W-1:0]  sample_target;

  // memories
  logic [WEIGHT_W-1:0] weight_mem [TABLE_DEPTH];
  logic [1:0]          mark_mem   [TABLE_DEPTH];
  logic [WEIGHT_W-1:0] w_q;
  logic [1:0]          mk_q;
  logic [INDEX_W-1:0]  rd_addr;
  logic                mk_we;
  logic [INDEX_W-1:0]  mk_wa;
  logic [1:0]          mk_wd;

  // batch and walk state
  logic [WEIGHT_W-1:0]      removed_mass;
  logic [COUNT_W-1:0]       accepted_count;
  logic [INDEX_W-1:0]       clr_addr;
  logic [INDEX_W-1:0]       idx_hold;
  logic [FRAC_W-1:0]        r_hold;
  logic [RHS_W-1:0]         rhs;
  logic [INDEX_W-1:0]       proc_idx;
  logic [WEIGHT_W-1:0]      prev_w;
  logic signed [SKIP_W-1:0] skipped;
  logic [INDEX_W-1:0]       drawn_reg;
  logic [WEIGHT_W-1:0]      cur_w;
  logic [WEIGHT_W-1:0]      cur_prev;
  logic                     cur_veto;
  logic                     cur_samp;

  // combinational terms
  logic [INDEX_W-1:0]        last_idx;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [WEIGHT_W:0]  mass;
  logic                      passes;
  logic                      is_last;
  logic [COUNT_W-1:0]        target;
  logic                      live;
  logic                      veto_do;
  logic                      acc_do;
  logic [COUNT_W-1:0]        count_new;

  always_comb begin
    if (entry_count == '0) begin
      last_idx = '0;
    end else if (entry_count > COUNT_W'(TABLE_DEPTH)) begin
      last_idx = '1;
    end else begin
      last_idx = INDEX_W'(entry_count - COUNT_W'(1));
    end
  end

  assign mass    = $signed({1'b0, w_q}) - $signed({1'b0, prev_w});
  assign diff    = $signed({{(DIFF_W-WEIGHT_W){1'b0}}, w_q}) - DIFF_W'(skipped);
  assign passes  = !diff[DIFF_W-1] &&
                   ((|diff[DIFF_W-2:FRAC_W]) ||
                    (RHS_W'({diff[FRAC_W-1:0], {FRAC_W{1'b0}}}) >= rhs));
  assign is_last = (proc_idx == last_idx);

  assign stat.walk_end   = (!mk_q[VETO_BIT] && passes) || is_last;
  assign stat.sweep_last = (clr_addr == '1);
  assign stat.out_free   = !out_valid || out_ready;

  assign target    = (sample_target == '0) ? COUNT_W'(1) : sample_target;
  assign live      = accepted_count < target;
  assign veto_do   = live && !with_replacement && !cur_veto;
  assign acc_do    = live && (with_replacement || !cur_samp);
  assign count_new = (acc_do && accepted_count != COUNT_MAX) ?
                     accepted_count + COUNT_W'(1) : accepted_count;

  always_comb begin
    priority if (cmd.walk) begin
      rd_addr = proc_idx + INDEX_W'(1);
    end else if (cmd.veto_prev) begin
      rd_addr = idx_hold - INDEX_W'(1);
    end else if (cmd.veto_cur) begin
      rd_addr = idx_hold;
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    mk_we = 1'b0;
    mk_wa = clr_addr;
    mk_wd = 2'b00;
    priority if (cmd.sweep) begin
      mk_we = 1'b1;
    end else if (cmd.veto_apply) begin
      mk_we = 1'b1;
      mk_wa = idx_hold;
      mk_wd = {1'b1, mk_q[SAMP_BIT]};
    end else if (cmd.decide) begin
      mk_we = 1'b1;
      mk_wa = drawn_reg;
      mk_wd = {cur_veto || (live && !with_replacement), cur_samp || acc_do};
    end else begin
      mk_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) weight_mem[entry_index] <= cumulative_weight;
    w_q <= weight_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mk_we) mark_mem[mk_wa] <= mk_wd;
    mk_q <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      with_replacement <= 1'b0;
      entry_count      <= COUNT_W'(TABLE_DEPTH);
      sample_target    <= COUNT_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WITH_REPL:   with_replacement <= cfg_data[0];
        CFG_ENTRY_COUNT: entry_count      <= cfg_data;
        CFG_SAMPLE_TGT:  sample_target    <= cfg_data;
        CFG_UNUSED:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      removed_mass   <= '0;
      accepted_count <= '0;
      clr_addr       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.sweep) clr_addr <= clr_addr + INDEX_W'(1);
      if (cmd.clear_batch) begin
        removed_mass   <= '0;
        accepted_count <= '0;
      end else if (cmd.veto_apply && !mk_q[VETO_BIT]) begin
        removed_mass <= add_mass(removed_mass, w_q, cur_prev);
      end else if (cmd.decide) begin
        accepted_count <= count_new;
        if (veto_do) removed_mass <= add_mass(removed_mass, cur_w, cur_prev);
      end
      if (cmd.decide) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_hold <= entry_index;
      r_hold   <= random_fraction;
    end
    if (cmd.setup) begin
      rhs      <= RHS_W'(r_hold) * RHS_W'(ONE_FX - removed_mass);
      proc_idx <= '0;
      prev_w   <= '0;
      skipped  <= '0;
    end
    if (cmd.walk) begin
      if (stat.walk_end) begin
        drawn_reg <= proc_idx;
        cur_w     <= w_q;
        cur_prev  <= prev_w;
        cur_veto  <= mk_q[VETO_BIT];
        cur_samp  <= mk_q[SAMP_BIT];
      end else begin
        proc_idx <= proc_idx + INDEX_W'(1);
        prev_w   <= w_q;
        if (mk_q[VETO_BIT]) skipped <= skipped + SKIP_W'(mass);
      end
    end
    if (cmd.veto_cur) begin
      cur_prev <= (idx_hold == '0) ? '0 : w_q;
    end
    if (cmd.decide) begin
      drawn_index <= drawn_reg;
      accepted    <= acc_do;
      batch_done  <= count_new >= target;
    end
  end

  a_removed_bounded: assert property (@(posedge clk) disable iff (rst)
    removed_mass <= ONE_FX)
    else $error("removed mass above one");

  a_walk_steps: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk && !stat.walk_end) |=> (proc_idx == $past(proc_idx) + INDEX_W'(1)))
    else $error("walk index did not advance");

  a_decide_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |=> (out_valid && drawn_index == $past(drawn_reg)))
    else $error("decided draw not presented");

endmodule

`default_nettype wire

// ===== design/weighted_index_sampler_with_veto_top.sv =====
// Top level of the weighted index sampler with veto: controller plus datapath.
`default_nettype none

// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------------------
// input    | in_valid / in_ready    | kind, entry_index, cumulative_weight, random_fraction
// output   | out_valid / out_ready  | drawn_index, accepted, batch_done
// config   | cfg_write (no wait)    | cfg_index, cfg_data
//
// A load is written as it is accepted; a veto reads the table twice, then applies the update.
// A draw sets up, then walks k entries (k = 1 .. entry_count, at least 1, at most 1024),
//   one table entry per cycle through the single read port of the weight table, then decides.
// Clear, and reset, sweep every entry of the mark memory, one entry a cycle, with in_ready low.
// A finished draw sits in the result register; loads, vetoes and clears are taken while it
//   waits, and a following draw stalls only in its final step until the result transfers.
module weighted_index_sampler_with_veto_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // config write port
  input  wire logic                              cfg_write,
  input  wire logic [wis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wis_pkg::CFG_W-1:0]         cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [wis_pkg::KIND_W-1:0]        kind,
  input  wire logic [wis_pkg::INDEX_W-1:0]       entry_index,
  input  wire logic [wis_pkg::WEIGHT_W-1:0]      cumulative_weight,
  input  wire logic [wis_pkg::FRAC_W-1:0]        random_fraction,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [wis_pkg::INDEX_W-1:0]            drawn_index,
  output logic                                   accepted,
  output logic                                   batch_done
);
  import wis_pkg::*;

  dp_cmd_t  cmd;   // per-cycle datapath commands from the sequencer
  dp_stat_t stat;  // walk end, sweep end, result register free

  // sequencer: idle, mark sweep, draw setup/walk/decide, three-step veto
  wis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // table and mark memories, renormalized CDF test, batch counters, result register
  wis_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .entry_index       (entry_index),
    .cumulative_weight (cumulative_weight),
    .random_fraction   (random_fraction),
    .cmd               (cmd),
    .stat              (stat),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .drawn_index       (drawn_index),
    .accepted          (accepted),
    .batch_done        (batch_done)
  );

endmodule

`default_nettype wire
